>>> rtl/rvd_pkg.sv
// ----------------------------------------------------------------------------
// rvd_pkg
// Shared types and constants of the radial vignette darkening pipeline.
// ----------------------------------------------------------------------------
package rvd_pkg;

  localparam int DIM_W   = 13;  // frame dimension register width
  localparam int COORD_W = 12;  // pixel coordinate width
  localparam int CH_W    = 8;   // color channel width
  localparam int R0_W    = 12;  // inner radius width
  localparam int SPAN_W  = 11;  // span width, rmax - r0 stays below 2^11
  localparam int D2_W    = 26;  // squared distance, padded to an even width
  localparam int ROOT_W  = D2_W / 2;
  localparam int M58_W   = 18;  // rmax * 58
  localparam int NUM_W   = SPAN_W + CH_W;  // t * max_opacity

  // floor(n / 100) = (n * R0_RECIP) >> R0_SHIFT for n below 2^18
  localparam int R0_FACTOR = 58;
  localparam int R0_RECIP_W = 19;
  localparam logic [R0_RECIP_W-1:0] R0_RECIP = 19'd335545;
  localparam int R0_SHIFT = 25;

  // floor(p / 255) = (p * DIV255_RECIP) >> DIV255_SHIFT for p up to 255 * 255
  localparam logic [15:0] DIV255_RECIP = 16'd32897;
  localparam int DIV255_SHIFT = 23;

  localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OPACITY  = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd768;
  localparam logic [CH_W-1:0]  MAX_OPACITY_RST  = 8'd0;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // per-pixel data that rides alongside the distance computation
  typedef struct packed {
    rgb_t              rgb;
    logic [R0_W-1:0]   r0;
    logic [SPAN_W-1:0] span;
    logic [CH_W-1:0]   opacity;
  } side_t;

endpackage

>>> rtl/rvd_geom.sv
// ----------------------------------------------------------------------------
// rvd_geom
// Centre offsets, squared distance, inner radius and span (four stages).
// ----------------------------------------------------------------------------
module rvd_geom
  import rvd_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [COORD_W-1:0] x,
  input  logic [COORD_W-1:0] y,
  input  rgb_t               rgb,
  input  logic [DIM_W-1:0]   frame_width,
  input  logic [DIM_W-1:0]   frame_height,
  input  logic [CH_W-1:0]    max_opacity,
  output logic               out_vld,
  output logic [D2_W-1:0]    d2,
  output side_t              side
);

  localparam logic [DIM_W-1:0] DIM_CAP =
    (MAX_DIM > 8191) ? 13'd8191 : DIM_W'(MAX_DIM);

  // stage 1
  logic [DIM_W-1:0]   w_sat;
  logic [DIM_W-1:0]   h_sat;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [COORD_W:0]   dx;
  logic [COORD_W:0]   dy;
  logic               vld1;
  logic [COORD_W-1:0] adx1;
  logic [COORD_W-1:0] ady1;
  logic [COORD_W-1:0] rmax1;
  logic [CH_W-1:0]    opacity1;
  rgb_t               rgb1;

  // stage 2
  logic                   vld2;
  logic [2*COORD_W-1:0]   sqx2;
  logic [2*COORD_W-1:0]   sqy2;
  logic [M58_W-1:0]       m58_2;
  logic [COORD_W-1:0]     rmax2;
  logic [CH_W-1:0]        opacity2;
  rgb_t                   rgb2;

  // stage 3
  logic                          vld3;
  logic [D2_W-1:0]               d2_3;
  logic [M58_W+R0_RECIP_W-1:0]   prod3;
  logic [COORD_W-1:0]            rmax3;
  logic [CH_W-1:0]               opacity3;
  rgb_t                          rgb3;

  logic [R0_W-1:0]   r0_next;
  logic [COORD_W-1:0] span_full;

  always_comb begin
    w_sat = (frame_width  > DIM_CAP) ? DIM_CAP : frame_width;
    h_sat = (frame_height > DIM_CAP) ? DIM_CAP : frame_height;
    cx = w_sat[DIM_W-1:1];
    cy = h_sat[DIM_W-1:1];
    dx = {1'b0, x} - {1'b0, cx};
    dy = {1'b0, y} - {1'b0, cy};
  end

  assign r0_next   = prod3[M58_W+R0_RECIP_W-1:R0_SHIFT];
  assign span_full = rmax3 - r0_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      vld3    <= vld2;
      out_vld <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offsets from the centre, magnitudes only
      adx1     <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ady1     <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      rmax1    <= (cx > cy) ? cx : cy;
      opacity1 <= max_opacity;
      rgb1     <= rgb;
      // stage 2: squares and rmax * 58
      sqx2     <= adx1 * adx1;
      sqy2     <= ady1 * ady1;
      m58_2    <= M58_W'(rmax1 * R0_FACTOR);
      rmax2    <= rmax1;
      opacity2 <= opacity1;
      rgb2     <= rgb1;
      // stage 3: sum of squares, reciprocal multiply for the divide by 100
      d2_3     <= D2_W'(sqx2) + D2_W'(sqy2);
      prod3    <= m58_2 * R0_RECIP;
      rmax3    <= rmax2;
      opacity3 <= opacity2;
      rgb3     <= rgb2;
      // stage 4: inner radius and span
      d2           <= d2_3;
      side.r0      <= r0_next;
      side.span    <= span_full[SPAN_W-1:0];
      side.opacity <= opacity3;
      side.rgb     <= rgb3;
    end
  end

endmodule

>>> rtl/rvd_sqrt.sv
// ----------------------------------------------------------------------------
// rvd_sqrt
// Pipelined floor square root, one result bit per step,
// thirteen steps spread over four stages.
// ----------------------------------------------------------------------------
module rvd_sqrt
  import rvd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [D2_W-1:0]   d2,
  input  side_t             in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] root,
  output side_t             out_side
);

  localparam int NSTAGE = 4;

  typedef struct packed {
    logic [D2_W-1:0]   v;
    logic [15:0]       rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  function automatic sq_t sq_step(sq_t s);
    sq_t         o;
    logic [15:0] rem;
    logic [14:0] trial;
    rem   = {s.rem[13:0], s.v[D2_W-1:D2_W-2]};
    trial = {s.root, 2'b01};
    o.v   = {s.v[D2_W-3:0], 2'b00};
    if (rem >= {1'b0, trial}) begin
      o.rem  = rem - {1'b0, trial};
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  sq_t   sq   [NSTAGE+1];
  logic  vld  [NSTAGE+1];
  side_t side [NSTAGE+1];

  assign sq[0].v    = d2;
  assign sq[0].rem  = '0;
  assign sq[0].root = '0;
  assign vld[0]     = in_vld;
  assign side[0]    = in_side;

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    localparam int CNT = (s == 0) ? 4 : 3;
    sq_t nxt;

    always_comb begin
      nxt = sq[s];
      for (int j = 0; j < CNT; j++) begin
        nxt = sq_step(nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[s+1]   <= nxt;
        side[s+1] <= side[s];
      end
    end
  end

  assign out_vld  = vld[NSTAGE];
  assign root     = sq[NSTAGE].root;
  assign out_side = side[NSTAGE];

endmodule

>>> rtl/rvd_div.sv
// ----------------------------------------------------------------------------
// rvd_div
// Opacity from the distance past the inner radius: clamp, scale and
// divide by the span over three stages.
// ----------------------------------------------------------------------------
module rvd_div
  import rvd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [ROOT_W-1:0] r,
  input  side_t             side,
  output logic              out_vld,
  output logic [CH_W-1:0]   alpha,
  output rgb_t              out_rgb
);

  // stage 1
  logic              pass;
  logic [ROOT_W-1:0] t_full;
  logic [SPAN_W-1:0] t_clip;
  logic              vld1;
  logic [NUM_W-1:0]  rem1;
  logic [SPAN_W-1:0] dvs1;
  rgb_t              rgb1;

  // stage 2
  logic              vld2;
  logic [NUM_W-1:0]  rem2;
  logic [SPAN_W-1:0] dvs2;
  logic [3:0]        qhi2;
  rgb_t              rgb2;

  logic [NUM_W-1:0]  rem_a;
  logic [3:0]        q_a;
  logic [NUM_W-1:0]  rem_b;
  logic [3:0]        q_b;

  always_comb begin
    pass   = (side.span == '0) || ({1'b0, side.r0} >= r);
    t_full = r - {1'b0, side.r0};
    t_clip = (t_full > ROOT_W'(side.span)) ? side.span : t_full[SPAN_W-1:0];
  end

  // quotient is below 256 since t never exceeds span, so eight steps suffice
  always_comb begin
    rem_a = rem1;
    q_a   = '0;
    for (int i = 7; i >= 4; i--) begin
      if (rem_a >= (NUM_W'(dvs1) << i)) begin
        rem_a = rem_a - (NUM_W'(dvs1) << i);
        q_a[i-4] = 1'b1;
      end
    end
    rem_b = rem2;
    q_b   = '0;
    for (int i = 3; i >= 0; i--) begin
      if (rem_b >= (NUM_W'(dvs2) << i)) begin
        rem_b = rem_b - (NUM_W'(dvs2) << i);
        q_b[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // a zero numerator over one gives zero opacity for passing pixels
      rem1    <= pass ? '0 : t_clip * side.opacity;
      dvs1    <= pass ? SPAN_W'(1) : side.span;
      rgb1    <= side.rgb;
      rem2    <= rem_a;
      dvs2    <= dvs1;
      qhi2    <= q_a;
      rgb2    <= rgb1;
      alpha   <= {qhi2, q_b};
      out_rgb <= rgb2;
    end
  end

endmodule

>>> rtl/rvd_shade.sv
// ----------------------------------------------------------------------------
// rvd_shade
// Scales each channel by (255 - alpha) / 255; the last stage is the
// result register.
// ----------------------------------------------------------------------------
module rvd_shade
  import rvd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [CH_W-1:0] alpha,
  input  rgb_t            in_rgb,
  output logic            out_vld,
  output rgb_t            out_rgb
);

  logic [CH_W-1:0]   inv;
  logic              vld1;
  logic [2*CH_W-1:0] pr1;
  logic [2*CH_W-1:0] pg1;
  logic [2*CH_W-1:0] pb1;
  logic [31:0]       qr;
  logic [31:0]       qg;
  logic [31:0]       qb;

  assign inv = FULL_SCALE - alpha;

  // divide by 255 through a reciprocal multiply, exact up to 255 * 255
  assign qr = pr1 * DIV255_RECIP;
  assign qg = pg1 * DIV255_RECIP;
  assign qb = pb1 * DIV255_RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr1 <= in_rgb.red   * inv;
      pg1 <= in_rgb.green * inv;
      pb1 <= in_rgb.blue  * inv;
      out_rgb.red   <= qr[DIV255_SHIFT+CH_W-1:DIV255_SHIFT];
      out_rgb.green <= qg[DIV255_SHIFT+CH_W-1:DIV255_SHIFT];
      out_rgb.blue  <= qb[DIV255_SHIFT+CH_W-1:DIV255_SHIFT];
    end
  end

endmodule

>>> rtl/radial_vignette_pixel_darken_unit.sv
// ----------------------------------------------------------------------------
// radial_vignette_pixel_darken_unit
// Darkens streamed RGB pixels by a radial vignette around the frame centre.
// ----------------------------------------------------------------------------
//  channel  signals                            direction  transfer when
//  cfg      cfg_valid/ready, cfg_index, data   in         valid & ready
//  pixel    pix_valid/stall, pix_x/y, in_rgb   in         valid & !stall
//  result   res_valid/stall, out_rgb           out        valid & !stall
//
//  one pixel per clock unless a held result stalls; the depth comes from the
//  geometry, the 13-step square root, the 8-step span divide and shading stages
//  rst is synchronous and resets valid bits and configuration registers
//  a held result stalls the whole pipeline, so pix_stall = res_valid & res_stall
//  cfg_ready stays high; the user writes registers while the pipeline is empty
// ----------------------------------------------------------------------------
module radial_vignette_pixel_darken_unit
  import rvd_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  logic [COORD_W-1:0]   pix_x,
  input  logic [COORD_W-1:0]   pix_y,
  input  logic [CH_W-1:0]      in_red,
  input  logic [CH_W-1:0]      in_green,
  input  logic [CH_W-1:0]      in_blue,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [CH_W-1:0]      out_red,
  output logic [CH_W-1:0]      out_green,
  output logic [CH_W-1:0]      out_blue
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [CH_W-1:0]  max_opacity;

  logic              en;
  rgb_t              in_rgb;
  logic              geom_vld;
  logic [D2_W-1:0]   geom_d2;
  side_t             geom_side;
  logic              sqrt_vld;
  logic [ROOT_W-1:0] sqrt_root;
  side_t             sqrt_side;
  logic              div_vld;
  logic [CH_W-1:0]   div_alpha;
  rgb_t              div_rgb;
  rgb_t              res_rgb;

  assign cfg_ready = 1'b1;
  assign en        = !(res_valid && res_stall);
  assign pix_stall = !en;

  assign in_rgb.red   = in_red;
  assign in_rgb.green = in_green;
  assign in_rgb.blue  = in_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      max_opacity  <= MAX_OPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_MAX_OPACITY:  max_opacity  <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  rvd_geom #(
    .MAX_DIM(MAX_DIM)
  ) u_geom (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_vld       (pix_valid),
    .x            (pix_x),
    .y            (pix_y),
    .rgb          (in_rgb),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .max_opacity  (max_opacity),
    .out_vld      (geom_vld),
    .d2           (geom_d2),
    .side         (geom_side)
  );

  rvd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (geom_vld),
    .d2       (geom_d2),
    .in_side  (geom_side),
    .out_vld  (sqrt_vld),
    .root     (sqrt_root),
    .out_side (sqrt_side)
  );

  rvd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (sqrt_vld),
    .r       (sqrt_root),
    .side    (sqrt_side),
    .out_vld (div_vld),
    .alpha   (div_alpha),
    .out_rgb (div_rgb)
  );

  rvd_shade u_shade (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (div_vld),
    .alpha   (div_alpha),
    .in_rgb  (div_rgb),
    .out_vld (res_valid),
    .out_rgb (res_rgb)
  );

  assign out_red   = res_rgb.red;
  assign out_green = res_rgb.green;
  assign out_blue  = res_rgb.blue;

endmodule

>>> rtl/rvd_checker.sv
// ----------------------------------------------------------------------------
// rvd_checker
// Port-level checks of the vignette unit, bound to the top level.
// ----------------------------------------------------------------------------
module rvd_checker
  import rvd_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            pix_stall,
  input logic            res_valid,
  input logic            res_stall,
  input logic [CH_W-1:0] out_red,
  input logic [CH_W-1:0] out_green,
  input logic [CH_W-1:0] out_blue
);

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_red)
      && $stable(out_green) && $stable(out_blue))
    else $error("result changed while stalled");

  // input side only backs up when a result is held
  a_stall: assert property (@(posedge clk) disable iff (rst)
    pix_stall == (res_valid && res_stall))
    else $error("pixel stall does not track held result");

  // pipeline comes out of reset empty
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind radial_vignette_pixel_darken_unit rvd_checker u_rvd_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial vignette darkening unit testbench
// Streams pixels through the vignette pipeline under several frame sizes and
// opacities, with random sender gaps and receiver stalls, and checks every
// result pixel against an independent prediction kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import rvd_pkg::*;

  localparam int FRAME_MAX    = 4096;
  localparam int INNER_PCT    = 58;
  localparam int PCT_SCALE    = 100;
  localparam int PIPE_DEPTH   = 13;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 700;
  localparam int REPORT_LIMIT = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    bit [COORD_W-1:0] x;
    bit [COORD_W-1:0] y;
    rgb_t             rgb;
  } pixel_t;

  class vignette_scoreboard;
    int unsigned frame_w;
    int unsigned frame_h;
    int unsigned opacity;
    rgb_t        darkened_q[$];
    int          n_checked;
    int          n_darkened;
    int          n_errors;

    function new();
      frame_w    = FRAME_WIDTH_RST;
      frame_h    = FRAME_HEIGHT_RST;
      opacity    = MAX_OPACITY_RST;
      n_checked  = 0;
      n_darkened = 0;
      n_errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:  frame_w = data;
        REG_FRAME_HEIGHT: frame_h = data;
        REG_MAX_OPACITY:  opacity = data[CH_W-1:0];
        default: ;
      endcase
    endfunction

    function int isqrt(longint v);
      int     root;
      longint trial;
      root = 0;
      for (int b = 13; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= v) root = int'(trial);
      end
      return root;
    endfunction

    function rgb_t darkened_rgb(pixel_t p);
      int     w, h, cx, cy, rmax, r0, span, dx, dy, r, t, a, keep;
      longint d2;
      rgb_t   c;
      c = p.rgb;
      w = (frame_w > FRAME_MAX) ? FRAME_MAX : frame_w;
      h = (frame_h > FRAME_MAX) ? FRAME_MAX : frame_h;
      cx = w / 2;
      cy = h / 2;
      rmax = (cx > cy) ? cx : cy;
      r0 = rmax * INNER_PCT / PCT_SCALE;
      span = rmax - r0;
      if (span > 0) begin
        dx = int'(p.x) - cx;
        dy = int'(p.y) - cy;
        d2 = longint'(dx) * dx + longint'(dy) * dy;
        r = isqrt(d2);
        if (r > r0) begin
          t = r - r0;
          if (t > span) t = span;
          a = t * int'(opacity) / span;
          if (a != 0) begin
            keep = int'(FULL_SCALE) - a;
            c.red   = CH_W'(int'(c.red) * keep / int'(FULL_SCALE));
            c.green = CH_W'(int'(c.green) * keep / int'(FULL_SCALE));
            c.blue  = CH_W'(int'(c.blue) * keep / int'(FULL_SCALE));
          end
        end
      end
      return c;
    endfunction

    function void note_pixel(pixel_t p);
      rgb_t c;
      c = darkened_rgb(p);
      if (c != p.rgb) n_darkened++;
      darkened_q.push_back(c);
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t exp_c;
      if (darkened_q.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT)
          $display("[%0t] result with no pixel pending: %h %h %h",
                   $realtime, got.red, got.green, got.blue);
        return;
      end
      exp_c = darkened_q.pop_front();
      n_checked++;
      if (got.red !== exp_c.red || got.green !== exp_c.green || got.blue !== exp_c.blue) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT)
          $display("[%0t] pixel %0d differs: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                   $realtime, n_checked, exp_c.red, exp_c.green, exp_c.blue,
                   got.red, got.green, got.blue);
      end
    endfunction

    function int pending();
      return darkened_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 pix_valid;
  logic                 pix_stall;
  logic [COORD_W-1:0]   pix_x;
  logic [COORD_W-1:0]   pix_y;
  logic [CH_W-1:0]      in_red;
  logic [CH_W-1:0]      in_green;
  logic [CH_W-1:0]      in_blue;
  logic                 res_valid;
  logic                 res_stall;
  logic [CH_W-1:0]      out_red;
  logic [CH_W-1:0]      out_green;
  logic [CH_W-1:0]      out_blue;

  logic hold_req;
  logic hold_done;

  vignette_scoreboard sb;
  int n_pixels;
  int n_settings;

  radial_vignette_pixel_darken_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: rotates through no, light, heavy and periodic stalls, plus one long hold
  initial begin
    int unsigned cyc;
    cyc = 0;
    res_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req && !hold_done) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end else begin
        case (stall_mode_t'((cyc / 300) % 4))
          STALL_NONE:     res_stall <= 1'b0;
          STALL_LIGHT:    res_stall <= ($urandom_range(0, 99) < 30);
          STALL_HEAVY:    res_stall <= ($urandom_range(0, 99) < 70);
          STALL_PERIODIC: res_stall <= ((cyc % 7) < 2);
          default:        res_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && res_valid === 1'b1 && res_stall === 1'b0)
      sb.check_pixel('{red: out_red, green: out_green, blue: out_blue});
  end

  function automatic pixel_t mk_pixel(int x, int y, int r, int g, int b);
    pixel_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.rgb.red = CH_W'(r);
    p.rgb.green = CH_W'(g);
    p.rgb.blue = CH_W'(b);
    return p;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int unsigned w, h;
    w = (sb.frame_w > FRAME_MAX) ? FRAME_MAX : sb.frame_w;
    h = (sb.frame_h > FRAME_MAX) ? FRAME_MAX : sb.frame_h;
    // mostly inside the frame, some anywhere in the coordinate range
    if (w == 0 || $urandom_range(0, 4) == 0) p.x = COORD_W'($urandom_range(0, 4095));
    else p.x = COORD_W'($urandom_range(0, w - 1));
    if (h == 0 || $urandom_range(0, 4) == 0) p.y = COORD_W'($urandom_range(0, 4095));
    else p.y = COORD_W'($urandom_range(0, h - 1));
    p.rgb.red   = CH_W'($urandom_range(0, 255));
    p.rgb.green = CH_W'($urandom_range(0, 255));
    p.rgb.blue  = CH_W'($urandom_range(0, 255));
    return p;
  endfunction

  function automatic int unsigned rand_dim();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1;
      2:       return FRAME_MAX;
      3:       return $urandom_range(FRAME_MAX + 1, 8191);
      4:       return $urandom_range(2, 40);
      default: return $urandom_range(1, FRAME_MAX);
    endcase
  endfunction

  function automatic int unsigned rand_opacity();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic push_pixel(input pixel_t p);
    pix_valid <= 1'b1;
    pix_x     <= p.x;
    pix_y     <= p.y;
    in_red    <= p.rgb.red;
    in_green  <= p.rgb.green;
    in_blue   <= p.rgb.blue;
    do @(posedge clk); while (pix_stall !== 1'b0);
    sb.note_pixel(p);
    n_pixels++;
  endtask

  task automatic idle_pixels(input int n);
    pix_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending and let every outstanding pixel come out
  task automatic drain();
    pix_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // upper data bits of the opacity write are random and must be dropped
  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned op);
    write_reg(REG_FRAME_WIDTH, DIM_W'(w));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(h));
    write_reg(REG_MAX_OPACITY, {(DIM_W - CH_W)'($urandom_range(0, 31)), op[CH_W-1:0]});
    write_reg(REG_UNUSED, DIM_W'($urandom_range(0, 8191)));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int count;
    int burst;
    int gap;
    sb = new();
    n_pixels   = 0;
    n_settings = 0;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    pix_valid = 1'b0;
    pix_x     = '0;
    pix_y     = '0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    hold_req  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: opacity zero leaves everything unchanged
    push_pixel(mk_pixel(0, 0, 255, 255, 255));
    push_pixel(mk_pixel(4095, 4095, 200, 100, 50));
    push_pixel(mk_pixel(512, 384, 1, 2, 3));
    drain();

    // inner radius 296, span 216 around (512,384)
    configure(1024, 768, 255);
    push_pixel(mk_pixel(512, 384, 255, 255, 255));
    push_pixel(mk_pixel(808, 384, 255, 255, 255));
    push_pixel(mk_pixel(809, 384, 255, 255, 255));
    push_pixel(mk_pixel(1024, 384, 255, 128, 1));
    push_pixel(mk_pixel(0, 0, 255, 255, 255));
    push_pixel(mk_pixel(4095, 4095, 0, 0, 0));
    push_pixel(mk_pixel(700, 600, 170, 85, 255));
    drain();

    // zero-sized frame has no span
    configure(0, 0, 200);
    push_pixel(mk_pixel(0, 0, 255, 255, 255));
    push_pixel(mk_pixel(4095, 4095, 17, 34, 68));
    drain();

    // small frame with a span of one
    configure(3, 2, 255);
    push_pixel(mk_pixel(1, 1, 255, 255, 255));
    push_pixel(mk_pixel(2, 1, 255, 255, 255));
    push_pixel(mk_pixel(4095, 0, 99, 200, 7));
    drain();

    // oversized dimensions saturate to the maximum frame
    configure(8191, 5000, 128);
    push_pixel(mk_pixel(2048, 2048, 255, 255, 255));
    push_pixel(mk_pixel(3235, 2048, 255, 255, 255));
    push_pixel(mk_pixel(3236, 2048, 255, 255, 255));
    push_pixel(mk_pixel(0, 0, 255, 255, 255));
    drain();

    configure(1, 4096, 64);
    push_pixel(mk_pixel(0, 0, 255, 255, 255));
    push_pixel(mk_pixel(0, 2048, 128, 64, 32));
    drain();

    count = 0;
    for (int ph = 0; count < RANDOM_ITEMS; ph++) begin
      configure(rand_dim(), rand_dim(), rand_opacity());
      // long receiver hold while the sender keeps offering pixels
      if (ph == 1) begin
        hold_req <= 1'b1;
        while (hold_done !== 1'b1) begin
          push_pixel(rand_pixel());
          count++;
        end
      end
      for (int n = 0; n < 100 + int'($urandom_range(0, 40)); ) begin
        burst = $urandom_range(1, 24);
        for (int i = 0; i < burst; i++) begin
          push_pixel(rand_pixel());
          count++;
          n++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) idle_pixels(gap);
      end
      drain();
    end

    drain();
    $display("sent %0d pixels over %0d register settings; %0d results checked, %0d darkened",
             n_pixels, n_settings, sb.n_checked, sb.n_darkened);
    $display("errors: %0d, pixels still outstanding: %0d", sb.n_errors, sb.pending());
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
